// ----- rtl/core/lkvc_pkg.sv -----
package lkvc_pkg;

  // Word widths of the payload and the configuration
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  // Operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_t;

  // Capacity after reset
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  // Value returned by a get that misses
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  // Value returned on every set
  localparam logic [DATA_W-1:0] SET_VALUE = '0;

endpackage

// ----- rtl/core/lru_key_value_cache_core.sv -----
// Fully associative key-value cache with least-recently-used replacement.
// Raise start for one cycle while busy is low to hand over a beat (operation,
// key, value). The block then walks all ENTRIES slots through one key
// comparator, one slot per cycle from the key memory's single read port,
// then passes through a finish and a decide state before busy falls, and a
// get that hits adds a response state for the value memory read. The result
// (hit, read_value, evicted) shows for exactly one cycle with done high and
// must be captured then: the receiver cannot stall it. Write cfg_wr_data
// with cfg_wr_en only while busy is low; 0 acts as 1 and values above
// ENTRIES act as ENTRIES.
module lru_key_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  // command
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic signed [31:0] key,
  input  logic signed [31:0] value,
  // result
  output logic               done,
  output logic               hit,
  output logic signed [31:0] read_value,
  output logic               evicted
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = IW;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int KW = lkvc_pkg::KEY_W;
  localparam int DW = lkvc_pkg::DATA_W;
  localparam int CW = lkvc_pkg::CFG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DECIDE,
    S_GET_RESP
  } state_t;

  state_t state;

  logic [CW-1:0]   capacity;
  logic [UW-1:0]   used;
  logic [IW-1:0]   idx;

  // latched beat
  logic            op_q;
  logic [KW-1:0]   key_q;
  logic [DW-1:0]   value_q;

  // compare stage
  logic            cmp_live;
  logic [IW-1:0]   cmp_idx;
  logic            hit_q;
  logic [IW-1:0]   found_idx;
  logic [RW-1:0]   found_rank;
  logic            free_q;
  logic [IW-1:0]   free_idx;
  logic [IW-1:0]   victim_idx;

  // memories and rank store
  logic [KW-1:0]   key_rd;
  logic [DW-1:0]   val_rd;
  logic            key_wr_en;
  logic            val_wr_en;
  logic [IW-1:0]   wr_idx;
  logic [IW-1:0]   val_rd_addr;
  logic            prom_en;
  logic [UW-1:0]   prom_old;
  logic            prom_set_valid;
  logic            ent_valid;
  logic [RW-1:0]   ent_rank;

  // effective capacity and fill test
  logic [8:0]      cap_ext;
  logic [8:0]      cap_eff;
  logic            has_room;
  logic            key_match;

  always_comb begin
    cap_ext = {4'b0, capacity};
    if (cap_ext == 9'd0) begin
      cap_eff = 9'd1;
    end else if (cap_ext > 9'(ENTRIES)) begin
      cap_eff = 9'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
    has_room = 9'(used) < cap_eff;
  end

  // Shared key comparator
  assign key_match = (key_rd == key_q);

  // Decide the write target and the promote request
  always_comb begin
    key_wr_en      = 1'b0;
    val_wr_en      = 1'b0;
    wr_idx         = found_idx;
    prom_en        = 1'b0;
    prom_old       = UW'(found_rank);
    prom_set_valid = 1'b0;
    if (state == S_DECIDE) begin
      if (hit_q) begin
        prom_en   = 1'b1;
        val_wr_en = (op_q == lkvc_pkg::OP_SET);
      end else if (op_q == lkvc_pkg::OP_SET) begin
        prom_en        = 1'b1;
        prom_set_valid = 1'b1;
        key_wr_en      = 1'b1;
        val_wr_en      = 1'b1;
        if (has_room) begin
          wr_idx   = free_idx;
          prom_old = used;
        end else begin
          wr_idx   = victim_idx;
          prom_old = used - UW'(1);
        end
      end
    end
  end

  assign val_rd_addr = found_idx;
  assign busy        = (state != S_IDLE);

  lkvc_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (KW),
    .AW    (IW)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (wr_idx),
    .wr_data (key_q),
    .rd_addr (idx),
    .rd_data (key_rd)
  );

  lkvc_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (DW),
    .AW    (IW)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (wr_idx),
    .wr_data (value_q),
    .rd_addr (val_rd_addr),
    .rd_data (val_rd)
  );

  lkvc_rank #(
    .ENTRIES (ENTRIES),
    .IW      (IW),
    .RW      (RW),
    .UW      (UW)
  ) u_rank (
    .clk            (clk),
    .rst            (rst),
    .prom_en        (prom_en),
    .prom_idx       (wr_idx),
    .prom_old       (prom_old),
    .prom_set_valid (prom_set_valid),
    .rd_idx         (cmp_idx),
    .rd_valid       (ent_valid),
    .rd_rank        (ent_rank)
  );

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Sequencer, compare stage and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      used     <= '0;
      idx      <= '0;
      cmp_live <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;

      // fold in one compared slot
      if (cmp_live) begin
        if (ent_valid && key_match && !hit_q) begin
          hit_q      <= 1'b1;
          found_idx  <= cmp_idx;
          found_rank <= ent_rank;
        end
        if (!ent_valid && !free_q) begin
          free_q   <= 1'b1;
          free_idx <= cmp_idx;
        end
        if (ent_valid && (UW'(ent_rank) == used - UW'(1))) begin
          victim_idx <= cmp_idx;
        end
      end

      case (state)
        S_IDLE: begin
          cmp_live <= 1'b0;
          if (start) begin
            op_q       <= operation;
            key_q      <= key;
            value_q    <= value;
            idx        <= '0;
            hit_q      <= 1'b0;
            free_q     <= 1'b0;
            found_idx  <= '0;
            found_rank <= '0;
            free_idx   <= '0;
            victim_idx <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // advance the read address, the compare follows in the next cycle
          cmp_live <= 1'b1;
          cmp_idx  <= idx;
          if (idx == IW'(ENTRIES - 1)) begin
            state <= S_FINISH;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_FINISH: begin
          cmp_live <= 1'b0;
          state    <= S_DECIDE;
        end
        S_DECIDE: begin
          hit        <= hit_q;
          evicted    <= 1'b0;
          read_value <= lkvc_pkg::SET_VALUE;
          if (op_q == lkvc_pkg::OP_GET) begin
            if (hit_q) begin
              state <= S_GET_RESP;
            end else begin
              read_value <= lkvc_pkg::MISS_VALUE;
              done       <= 1'b1;
              state      <= S_IDLE;
            end
          end else begin
            if (!hit_q) begin
              if (has_room) begin
                used <= used + UW'(1);
              end else begin
                evicted <= 1'b1;
              end
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_GET_RESP: begin
          read_value <= val_rd;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/lkvc_ram.sv -----
module lkvc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/lkvc_rank.sv -----
module lkvc_rank #(
  parameter int ENTRIES = 16,
  parameter int IW      = 4,
  parameter int RW      = 4,
  parameter int UW      = 5
) (
  input  logic          clk,
  input  logic          rst,
  // promote request
  input  logic          prom_en,
  input  logic [IW-1:0] prom_idx,
  input  logic [UW-1:0] prom_old,
  input  logic          prom_set_valid,
  // lookup of one entry
  input  logic [IW-1:0] rd_idx,
  output logic          rd_valid,
  output logic [RW-1:0] rd_rank
);

  logic [ENTRIES-1:0] valid;
  logic [RW-1:0]      rank [ENTRIES];

  // Age every valid entry more recent than the promoted one, zero the promoted one
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (prom_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IW'(i) == prom_idx) begin
          rank[i] <= '0;
          if (prom_set_valid) begin
            valid[i] <= 1'b1;
          end
        end else if (valid[i] && (UW'(rank[i]) < prom_old)) begin
          rank[i] <= rank[i] + RW'(1);
        end
      end
    end
  end

  // Select the entry under compare
  assign rd_valid = valid[rd_idx];
  assign rd_rank  = rank[rd_idx];

endmodule
